// ----- rtl/mncs_pkg.sv -----
`timescale 1ns / 1ps

package mncs_pkg;

  localparam int unsigned SEQ_STEPS          = 8;
  localparam int unsigned CLOCKS_PER_QUARTER = 24;

  localparam int unsigned STEP_W = $clog2(SEQ_STEPS);
  localparam int unsigned DIST_W = $clog2(SEQ_STEPS + 1);
  localparam int unsigned CC_W   = $clog2(CLOCKS_PER_QUARTER);
  localparam int unsigned TGT_W  = 4;

  localparam logic [CC_W-1:0] CC_LAST = CC_W'(CLOCKS_PER_QUARTER - 1);
  localparam logic [CC_W-1:0] CC_HALF = CC_W'(CLOCKS_PER_QUARTER / 2);

  // Input operations.
  localparam logic [1:0] OP_MIDI    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // MIDI byte codes and status nibbles.
  localparam logic [7:0] CLOCK_BYTE    = 8'hF8;
  localparam logic [4:0] REALTIME_TOP  = 5'b11111;
  localparam logic [3:0] ST_NONE       = 4'h0;
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_PROG       = 4'hC;
  localparam logic [3:0] ST_SYSTEM     = 4'hF;

  localparam logic [TGT_W-1:0] SWITCH_STEP = TGT_W'(3);
  localparam logic [6:0]       OCTAVE      = 7'd12;

  localparam logic [4:0] LISTEN_ALL = 5'h1F;
  localparam logic       REG_LISTEN = 1'b0;

  // One command handed from the parser to the sequencer side.
  typedef struct packed {
    logic             step_pulse;
    logic             go_step;
    logic [TGT_W-1:0] target;
    logic             led_wr;
    logic             led_val;
  } cmd_t;

  // Note number modulo an octave, with a reciprocal multiply (valid for 7 bits).
  function automatic logic [TGT_W-1:0] note_mod_octave(input logic [6:0] note);
    logic [12:0] prod;
    logic [3:0]  quot;
    logic [6:0]  mult;
    logic [6:0]  rem;
    prod = 13'(note) * 13'd43;
    quot = prod[12:9];
    mult = {3'b000, quot} * OCTAVE;
    rem  = note - mult;
    return rem[TGT_W-1:0];
  endfunction

  function automatic logic [1:0] data_length(input logic [3:0] status);
    logic [1:0] len;
    if (status == ST_PROG) begin
      len = 2'd1;
    end else if (status >= ST_NOTE_OFF && status < ST_SYSTEM) begin
      len = 2'd2;
    end else begin
      len = 2'd0;
    end
    return len;
  endfunction

endpackage

// ----- rtl/mncs_if.sv -----
`timescale 1ns / 1ps

interface mncs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source(output valid, output op, output data_byte, input ready);
  modport sink(input valid, input op, input data_byte, output ready);
endinterface

interface mncs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] advance_pulses;
  logic       led_on;
  logic [2:0] step_position;

  modport source(output valid, output advance_pulses, output led_on,
                 output step_position, input ready);
  modport sink(input valid, input advance_pulses, input led_on,
               input step_position, output ready);
endinterface

// ----- rtl/mncs_front.sv -----
`timescale 1ns / 1ps

module mncs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  mncs_in_if.sink            in_i,
  input  logic [4:0]         listen_channel_i,
  input  logic               full_i,
  output logic               push_o,
  output mncs_pkg::cmd_t     cmd_o
);

  logic [3:0]                 status_q, status_d;
  logic [3:0]                 chan_q, chan_d;
  logic [1:0]                 expect_q, expect_d;
  logic [1:0]                 recv_q, recv_d;
  logic [6:0]                 first_q, first_d;
  logic [mncs_pkg::CC_W-1:0]  cc_q, cc_d;
  logic [1:0]                 recv_inc;
  logic                       chan_match;
  logic [7:0]                 b;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign b          = in_i.data_byte;
  assign recv_inc   = recv_q + 2'd1;

  // A listen channel of all ones takes every channel; other negatives take none.
  assign chan_match = (listen_channel_i == mncs_pkg::LISTEN_ALL) ||
                      (!listen_channel_i[4] && listen_channel_i[3:0] == chan_q);

  always_comb begin
    status_d = status_q;
    chan_d   = chan_q;
    expect_d = expect_q;
    recv_d   = recv_q;
    first_d  = first_q;
    cc_d     = cc_q;
    cmd_o    = '0;
    unique case (in_i.op)
      mncs_pkg::OP_MIDI: begin
        if (b[7:3] == mncs_pkg::REALTIME_TOP) begin
          if (b == mncs_pkg::CLOCK_BYTE) begin
            cc_d = (cc_q == mncs_pkg::CC_LAST) ? '0 : cc_q + 1'b1;
            cmd_o.step_pulse = (cc_d == '0) || (cc_d == mncs_pkg::CC_HALF);
          end
        end else if (b[7]) begin
          chan_d   = b[3:0];
          status_d = b[7:4];
          expect_d = mncs_pkg::data_length(b[7:4]);
          recv_d   = 2'd0;
        end else if (status_q != mncs_pkg::ST_NONE && expect_q != 2'd0) begin
          if (recv_q == 2'd0) begin
            first_d = b[6:0];
          end
          recv_d = recv_inc;
          if (recv_inc >= expect_q) begin
            recv_d = 2'd0;
            if (chan_match) begin
              if (status_q == mncs_pkg::ST_NOTE_OFF) begin
                cmd_o.led_wr  = 1'b1;
                cmd_o.led_val = 1'b0;
              end else if (status_q == mncs_pkg::ST_NOTE_ON) begin
                cmd_o.led_wr = 1'b1;
                if (b[6:0] == 7'd0) begin
                  cmd_o.led_val = 1'b0;
                end else begin
                  cmd_o.led_val = 1'b1;
                  cmd_o.go_step = 1'b1;
                  cmd_o.target  = mncs_pkg::note_mod_octave(first_q);
                end
              end
            end
          end
        end
      end
      mncs_pkg::OP_PRESS: begin
        cmd_o.led_wr  = 1'b1;
        cmd_o.led_val = 1'b1;
        cmd_o.go_step = 1'b1;
        cmd_o.target  = mncs_pkg::SWITCH_STEP;
      end
      mncs_pkg::OP_RELEASE: begin
        cmd_o.led_wr  = 1'b1;
        cmd_o.led_val = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= mncs_pkg::ST_NONE;
      chan_q   <= '0;
      expect_q <= '0;
      recv_q   <= '0;
      cc_q     <= '0;
    end else if (push_o) begin
      status_q <= status_d;
      chan_q   <= chan_d;
      expect_q <= expect_d;
      recv_q   <= recv_d;
      cc_q     <= cc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      first_q <= first_d;
    end
  end

endmodule

// ----- rtl/mncs_queue.sv -----
`timescale 1ns / 1ps

module mncs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mncs_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mncs_pkg::cmd_t cmd_o
);

  mncs_pkg::cmd_t slot_q [2];
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/mncs_back.sv -----
`timescale 1ns / 1ps

module mncs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mncs_pkg::cmd_t cmd_i,
  output logic           pop_o,
  mncs_out_if.source     out_o
);

  localparam int unsigned SW = mncs_pkg::STEP_W;
  localparam int unsigned DW = mncs_pkg::DIST_W;

  logic [SW-1:0] pos_q, pos_d;
  logic          led_q, led_d;
  logic          ovalid_q, ovalid_d;
  logic [3:0]    pulses_q, pulses_d;
  logic [DW-1:0] fwd_steps;
  logic [DW-1:0] tgt_ext;
  logic [DW-1:0] pos_ext;
  logic          tgt_ok;

  assign pop_o   = valid_i && (!ovalid_q || out_o.ready);
  assign tgt_ok  = 5'(cmd_i.target) < 5'(mncs_pkg::SEQ_STEPS);
  assign tgt_ext = DW'(cmd_i.target);
  assign pos_ext = DW'(pos_q);

  // Forward distance to the target; standing on it means one full turn.
  always_comb begin
    if (tgt_ext > pos_ext) begin
      fwd_steps = tgt_ext - pos_ext;
    end else begin
      fwd_steps = tgt_ext + DW'(mncs_pkg::SEQ_STEPS) - pos_ext;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    led_d    = led_q;
    pulses_d = pulses_q;
    ovalid_d = ovalid_q && !out_o.ready;
    if (pop_o) begin
      ovalid_d = 1'b1;
      pulses_d = 4'd0;
      if (cmd_i.led_wr) begin
        led_d = cmd_i.led_val;
      end
      if (cmd_i.step_pulse) begin
        pulses_d = 4'd1;
        pos_d    = (pos_q == SW'(mncs_pkg::SEQ_STEPS - 1)) ? '0 : pos_q + 1'b1;
      end else if (cmd_i.go_step && tgt_ok) begin
        pulses_d = (5'(fwd_steps) > 5'd15) ? 4'd15 : 4'(fwd_steps);
        pos_d    = SW'(cmd_i.target);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= SW'(mncs_pkg::SEQ_STEPS - 1);
      led_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      led_q    <= led_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pulses_q <= pulses_d;
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.advance_pulses = pulses_q;
  assign out_o.led_on         = led_q;
  assign out_o.step_position  = 3'(pos_q);

endmodule

// ----- rtl/midi_note_clock_step_sequencer.sv -----
`timescale 1ns / 1ps

// MIDI note and clock step sequencer controller.
// The in_i channel carries one item per transfer: a received MIDI byte or a
// switch press or release. The out_o channel returns exactly one result per
// item: the advance pulses to send, the LED state and the step position.
// The listen channel register sits at APB byte address 0; writes land on the
// access cycle and pready is always high. Write it only while no item is in
// flight.
// A parser accepts and classifies items into a two-entry command queue; the
// sequencer side drains that queue into the output register. A result passes
// through a queue entry and then the output register before it is valid on
// out_o, and one item per cycle is sustained while the receiver is ready.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_i.ready falls once both queue entries are taken.
// Reset clears the running status and the clock count, puts the sequencer on
// its last step with the LED off, and sets the listen channel to all
// channels.

module midi_note_clock_step_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  mncs_in_if.sink     in_i,
  mncs_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]     listen_q;
  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  mncs_pkg::cmd_t cmd_in;
  mncs_pkg::cmd_t cmd_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mncs_pkg::REG_LISTEN) ? {{27{listen_q[4]}}, listen_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q <= mncs_pkg::LISTEN_ALL;
    end else if (psel && penable && pwrite && paddr[2] == mncs_pkg::REG_LISTEN) begin
      listen_q <= pwdata[4:0];
    end
  end

  mncs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_i),
    .listen_channel_i (listen_q),
    .full_i           (full),
    .push_o           (push),
    .cmd_o            (cmd_in)
  );

  mncs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  mncs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- sim/tb_midi_note_clock_step_sequencer.sv -----
`timescale 1ns / 1ps

module tb_midi_note_clock_step_sequencer;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [2:0] LISTEN_ADDR = 3'(4 * mncs_pkg::REG_LISTEN);
  localparam int         HOLD_CYCLES = 64;
  localparam int         PHASE_ITEMS = 60;
  localparam int         NUM_PHASES  = 6;
  localparam int         DRAIN_WAIT  = 6;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    logic [3:0] pulses;
    logic       led;
    logic [2:0] step;
  } step_result_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [7:0]   data;
    logic         fixed;
    step_result_t res;
  } dir_row_t;

  // Rows with a typed result can be read off directly; the rest go to the predictor.
  localparam dir_row_t DIR_ROWS [26] = '{
    '{mncs_pkg::OP_MIDI,    8'h40, 1'b1, '{4'd0, 1'b0, 3'd7}},  // data before any status
    '{OP_UNUSED,            8'hFF, 1'b1, '{4'd0, 1'b0, 3'd7}},
    '{mncs_pkg::OP_PRESS,   8'h00, 1'b1, '{4'd4, 1'b1, 3'd3}},
    '{mncs_pkg::OP_PRESS,   8'hFF, 1'b1, '{4'd8, 1'b1, 3'd3}},  // already there: full turn
    '{mncs_pkg::OP_RELEASE, 8'h00, 1'b1, '{4'd0, 1'b0, 3'd3}},
    '{mncs_pkg::OP_MIDI,    8'h90, 1'b1, '{4'd0, 1'b0, 3'd3}},
    '{mncs_pkg::OP_MIDI,    8'h00, 1'b1, '{4'd0, 1'b0, 3'd3}},
    '{mncs_pkg::OP_MIDI,    8'h7F, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'h43, 1'b0, '0},                   // running status
    '{mncs_pkg::OP_MIDI,    8'h00, 1'b0, '0},                   // zero velocity
    '{mncs_pkg::OP_MIDI,    8'h47, 1'b0, '0},                   // note B, step out of range
    '{mncs_pkg::OP_MIDI,    8'h01, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'hF8, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'hFF, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'hFA, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'h8F, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'h3C, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'h40, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'hC3, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'h05, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'hF0, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'h7F, 1'b0, '0},                   // data under system status
    '{mncs_pkg::OP_MIDI,    8'hF7, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'hA0, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'h12, 1'b0, '0},
    '{mncs_pkg::OP_MIDI,    8'h34, 1'b0, '0}
  };

  localparam logic signed [4:0] PHASE_LISTEN [NUM_PHASES] = '{
    -5'sd1, 5'sd15, -5'sd16, 5'sd0, -5'sd2, 5'sd7
  };
  localparam int SRC_IDLE  [4] = '{0, 67, 0, 10};
  localparam int SINK_STALL [4] = '{0, 0, 67, 10};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mncs_in_if  in_bus();
  mncs_out_if out_bus();

  midi_note_clock_step_sequencer DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state.
  logic signed [4:0] listen_ch;
  logic [3:0]        run_status;
  logic [3:0]        msg_chan;
  logic [1:0]        data_needed;
  logic [1:0]        data_seen;
  logic [6:0]        note_held;
  logic [4:0]        clk_cnt;
  logic [2:0]        step_pos;
  logic              led_st;

  step_result_t exp_results [$];
  int           fail_cnt;
  int           items_sent;
  int           src_idle_pct;
  int           sink_stall_pct;
  bit           hold_req;
  bit           hold_done;
  logic         item_fixed;
  step_result_t item_fixed_res;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int advance_to(input int target);
    int n;
    n = 0;
    if (target >= mncs_pkg::SEQ_STEPS) return 0;
    do begin
      step_pos = (int'(step_pos) + 1 >= mncs_pkg::SEQ_STEPS) ? 3'd0 : step_pos + 3'd1;
      n++;
    end while (int'(step_pos) != target);
    return n;
  endfunction

  function automatic int finish_message(input logic [6:0] second);
    if (listen_ch != mncs_pkg::LISTEN_ALL && int'(listen_ch) != int'(msg_chan)) return 0;
    if (run_status == mncs_pkg::ST_NOTE_OFF) begin
      led_st = 1'b0;
    end else if (run_status == mncs_pkg::ST_NOTE_ON) begin
      if (second == 7'd0) begin
        led_st = 1'b0;
      end else begin
        led_st = 1'b1;
        return advance_to(int'(note_held) % 12);
      end
    end
    return 0;
  endfunction

  function automatic int midi_byte_pulses(input logic [7:0] b);
    if (b[7:3] == mncs_pkg::REALTIME_TOP) begin
      if (b == mncs_pkg::CLOCK_BYTE) begin
        clk_cnt = clk_cnt + 5'd1;
        if (clk_cnt >= mncs_pkg::CLOCKS_PER_QUARTER) clk_cnt = 5'd0;
        if (clk_cnt == 5'd0 || clk_cnt == mncs_pkg::CLOCKS_PER_QUARTER / 2)
          return advance_to((int'(step_pos) + 1 >= mncs_pkg::SEQ_STEPS) ?
                            0 : int'(step_pos) + 1);
      end
      return 0;
    end
    if (b[7]) begin
      msg_chan    = b[3:0];
      run_status  = b[7:4];
      if (run_status == mncs_pkg::ST_PROG) begin
        data_needed = 2'd1;
      end else if (run_status >= mncs_pkg::ST_NOTE_OFF &&
                   run_status < mncs_pkg::ST_SYSTEM) begin
        data_needed = 2'd2;
      end else begin
        data_needed = 2'd0;
      end
      data_seen   = 2'd0;
      return 0;
    end
    if (run_status == mncs_pkg::ST_NONE || data_needed == 2'd0) return 0;
    if (data_seen == 2'd0) note_held = b[6:0];
    data_seen = data_seen + 2'd1;
    if (data_seen >= data_needed) begin
      data_seen = 2'd0;
      return finish_message(b[6:0]);
    end
    return 0;
  endfunction

  function automatic step_result_t predict_item(input logic [1:0] op, input logic [7:0] b);
    int           n;
    step_result_t r;
    n = 0;
    case (op)
      mncs_pkg::OP_MIDI: n = midi_byte_pulses(b);
      mncs_pkg::OP_PRESS: begin
        led_st = 1'b1;
        n = advance_to(int'(mncs_pkg::SWITCH_STEP));
      end
      mncs_pkg::OP_RELEASE: led_st = 1'b0;
      default: ;
    endcase
    r.pulses = (n > 15) ? 4'd15 : 4'(n);
    r.led    = led_st;
    r.step   = step_pos;
    return r;
  endfunction

  // Predictions are made at the input transfer and compared at the output transfer.
  always @(posedge clk_i) begin
    step_result_t pred;
    step_result_t got;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        pred = predict_item(in_bus.op, in_bus.data_byte);
        exp_results.push_back(item_fixed ? item_fixed_res : pred);
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.advance_pulses, out_bus.led_on, out_bus.step_position};
        if (exp_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected result: pulses=%0d led=%0b step=%0d",
                     got.pulses, got.led, got.step);
        end else begin
          pred = exp_results.pop_front();
          if (got.pulses !== pred.pulses || got.led !== pred.led || got.step !== pred.step)
          begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("mismatch: exp pulses=%0d led=%0b step=%0d, got %0d %0b %0d",
                       pred.pulses, pred.led, pred.step, got.pulses, got.led, got.step);
          end
        end
      end
    end
  end

  // Receiver side, including one long hold-off so the block backs up.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic fixed,
                           input step_result_t fixed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.op        <= op;
    in_bus.data_byte <= b;
    item_fixed       <= fixed;
    item_fixed_res   <= fixed_res;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_midi(input logic [7:0] b);
    send_item(mncs_pkg::OP_MIDI, b, 1'b0, '0);
  endtask

  task automatic maybe_realtime();
    if ($urandom_range(6) == 0) send_midi(8'($urandom_range(8'hFF, 8'hF8)));
  endtask

  // Called at a falling edge; returns at a falling edge once nothing is in flight.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_cycle(input logic wr, input logic [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LISTEN_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_listen(input logic signed [4:0] chan);
    apb_cycle(1'b1, 32'(chan));
    listen_ch = chan;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[4:0] !== chan) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("listen channel readback: expected %0h, got %0h", chan, prdata[4:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [3:0] pick_channel();
    if (listen_ch >= 0 && $urandom_range(9) < 6) return listen_ch[3:0];
    return 4'($urandom_range(15));
  endfunction

  // One burst of traffic: mostly well-formed messages with random content, some noise.
  task automatic gen_burst();
    int         kind;
    int         cnt;
    logic [3:0] ch;
    kind = $urandom_range(99);
    ch   = pick_channel();
    if (kind < 25) begin
      cnt = $urandom_range(30, 1);
      repeat (cnt) send_midi(mncs_pkg::CLOCK_BYTE);
    end else if (kind < 55) begin
      if ($urandom_range(9) < 6) send_midi({mncs_pkg::ST_NOTE_ON, ch});
      send_midi(8'($urandom_range(127)));
      maybe_realtime();
      send_midi(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(127, 1)));
    end else if (kind < 65) begin
      if ($urandom_range(9) < 6) send_midi({mncs_pkg::ST_NOTE_OFF, ch});
      send_midi(8'($urandom_range(127)));
      maybe_realtime();
      send_midi(8'($urandom_range(127)));
    end else if (kind < 75) begin
      send_item(2'($urandom_range(3, 1)), 8'($urandom_range(255)), 1'b0, '0);
    end else if (kind < 85) begin
      send_midi({4'($urandom_range(4'hE, 4'hA)), ch});
      cnt = $urandom_range(3);
      repeat (cnt) send_midi(8'($urandom_range(127)));
    end else if (kind < 92) begin
      send_midi(8'($urandom_range(8'hF7, 8'hF0)));
      cnt = $urandom_range(3);
      repeat (cnt) send_midi(8'($urandom_range(127)));
    end else begin
      send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  initial begin
    int target;
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.op        = mncs_pkg::OP_MIDI;
    in_bus.data_byte = 8'h00;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    item_fixed       = 1'b0;
    item_fixed_res   = '0;
    fail_cnt         = 0;
    items_sent       = 0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    hold_req         = 1'b0;
    hold_done        = 1'b0;
    listen_ch        = mncs_pkg::LISTEN_ALL;
    run_status       = mncs_pkg::ST_NONE;
    msg_chan         = 4'd0;
    data_needed      = 2'd0;
    data_seen        = 2'd0;
    note_held        = 7'd0;
    clk_cnt          = 5'd0;
    step_pos         = 3'(mncs_pkg::SEQ_STEPS - 1);
    led_st           = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].data, DIR_ROWS[i].fixed, DIR_ROWS[i].res);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_listen(PHASE_LISTEN[p]);
      src_idle_pct   = SRC_IDLE[p % 4];
      sink_stall_pct = SINK_STALL[p % 4];
      if (p == 0) hold_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) gen_burst();
      drain();
    end

    if (exp_results.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
